>>> rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define AAPM_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("aapm assertion failed");

// Next-cycle implication, off while reset is high.
`define AAPM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("aapm assertion failed");

// Checked on the cycle after reset was high.
`define AAPM_ASSERT_AFTER_RST(lbl, clk, rst, cons) \
  lbl: assert property (@(posedge clk) (rst) |=> (cons)) \
    else $error("aapm assertion failed");

`endif

>>> rtl/core/aapm_pkg.sv
// Shared types, constants and the segment angle table of the angle map.
package aapm_pkg;

  localparam int BRK_W      = 12;
  localparam int ANG_W      = 16;
  localparam int AVG_W      = 12;
  localparam int SPAN_W     = BRK_W + 1;
  localparam int NUM_BRK    = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int FRAC_SH    = 16;
  localparam int SEG_ANG_W  = 32;

  // pi/4 in Q0.29
  localparam int QPI_W = 30;
  localparam logic signed [QPI_W-1:0] QPI_FINE = 30'sd421657428;

  localparam logic [BRK_W-1:0] BRK0_RST = 12'd0;
  localparam logic [BRK_W-1:0] BRK1_RST = 12'd1024;
  localparam logic [BRK_W-1:0] BRK2_RST = 12'd2048;
  localparam logic [BRK_W-1:0] BRK3_RST = 12'd3072;
  localparam logic [BRK_W-1:0] BRK4_RST = 12'd4095;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BREAK_0    = 3'd0,
    REG_BREAK_1    = 3'd1,
    REG_BREAK_2    = 3'd2,
    REG_BREAK_3    = 3'd3,
    REG_BREAK_4    = 3'd4,
    REG_BASE_ANGLE = 3'd5
  } cfg_reg_t;

  typedef logic [1:0] seg_t;
  typedef logic [NUM_BRK-1:0][BRK_W-1:0] brk_vec_t;

  typedef struct packed {
    brk_vec_t                brk;
    logic signed [ANG_W-1:0] base_angle;
  } cfg_t;

  // k * pi/4 in Q2.29
  function automatic logic signed [SEG_ANG_W-1:0] seg_angle(input seg_t k);
    logic signed [SEG_ANG_W-1:0] r;
    case (k)
      2'd0:    r = 32'sd0;
      2'd1:    r = 32'sd421657428;
      2'd2:    r = 32'sd843314856;
      2'd3:    r = 32'sd1264972284;
      default: r = 32'sd0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/core/adc_average_piecewise_angle_map_unit.sv
// Top level: averages potentiometer samples and maps each mean to a joint angle.
// Input channel (in_valid / in_stall / sample): one raw converter reading per
// item. Every AVG_SAMPLES items close a group; the group sum goes into a
// two-entry queue and the front end keeps taking samples of the next group.
// in_stall rises only when the group-closing item finds the queue full.
// Output channel (out_valid / out_stall / avg_raw / angle / saturated): one
// item per group. avg_raw is the truncated mean, angle the Q2.13 radian
// angle by piecewise-linear interpolation over five breakpoints, clipped
// with saturated set. A stalled output holds its item; the back end waits
// in its last step until the output register frees up.
// The back end handles one group sum at a time: mean, segment pick, then the
// one-bit-per-cycle serial divider (DVD_W = wider of mean and AVG_W + 29,
// 41 at defaults); a zero-width segment skips the divider. It pops the next
// sum from the queue only after its result has gone to the output register.
// Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): always
// ready; indexes 0..4 are breakpoints, 5 the base angle, others ignored.
// Write only while the block is idle.
// Reset (rst, synchronous): empties the queue and the partial group, clears
// out_valid and restores the default breakpoints and base angle.
module adc_average_piecewise_angle_map_unit
  import aapm_pkg::*;
#(
  parameter int AVG_SAMPLES = 4,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [SAMPLE_BITS-1:0]  sample,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [AVG_W-1:0]        avg_raw,
  output logic signed [ANG_W-1:0] angle,
  output logic                    saturated,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  localparam int SUM_W = SAMPLE_BITS + $clog2(AVG_SAMPLES);

  cfg_t cfg;

  logic             push;
  logic [SUM_W-1:0] push_data;
  logic             fifo_full;
  logic             pop;
  logic [SUM_W-1:0] pop_data;
  logic             fifo_empty;

  // configuration registers, written any cycle
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.brk[0]     <= BRK0_RST;
      cfg.brk[1]     <= BRK1_RST;
      cfg.brk[2]     <= BRK2_RST;
      cfg.brk[3]     <= BRK3_RST;
      cfg.brk[4]     <= BRK4_RST;
      cfg.base_angle <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_BREAK_0:    cfg.brk[0]     <= cfg_data[BRK_W-1:0];
        REG_BREAK_1:    cfg.brk[1]     <= cfg_data[BRK_W-1:0];
        REG_BREAK_2:    cfg.brk[2]     <= cfg_data[BRK_W-1:0];
        REG_BREAK_3:    cfg.brk[3]     <= cfg_data[BRK_W-1:0];
        REG_BREAK_4:    cfg.brk[4]     <= cfg_data[BRK_W-1:0];
        REG_BASE_ANGLE: cfg.base_angle <= $signed(cfg_data[ANG_W-1:0]);
        default: ;
      endcase
    end
  end

  // sample accumulation
  aapm_front #(
    .AVG_SAMPLES (AVG_SAMPLES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .sample    (sample),
    .push      (push),
    .push_data (push_data),
    .fifo_full (fifo_full)
  );

  // group sums waiting for the back end
  aapm_fifo #(
    .WIDTH (SUM_W)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (fifo_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (fifo_empty)
  );

  // mean, interpolation and output register
  aapm_back #(
    .AVG_SAMPLES (AVG_SAMPLES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .pop        (pop),
    .pop_data   (pop_data),
    .fifo_empty (fifo_empty),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .avg_raw    (avg_raw),
    .angle      (angle),
    .saturated  (saturated)
  );

endmodule

>>> rtl/core/aapm_fifo.sv
// Two-entry queue of group sums between the front and back ends.
module aapm_fifo #(
  parameter int WIDTH = 14
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

>>> rtl/core/aapm_front.sv
// Front end: takes samples, sums each group and queues the finished sum.
module aapm_front #(
  parameter int AVG_SAMPLES = 4,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [SAMPLE_BITS-1:0] sample,
  output logic                   push,
  output logic [SAMPLE_BITS+$clog2(AVG_SAMPLES)-1:0] push_data,
  input  logic                   fifo_full
);

  localparam int SUM_W = SAMPLE_BITS + $clog2(AVG_SAMPLES);
  localparam int CNT_W = (AVG_SAMPLES > 1) ? $clog2(AVG_SAMPLES) : 1;

  logic [SUM_W-1:0] sample_sum;
  logic [CNT_W-1:0] sample_count;
  logic [SUM_W-1:0] sum_add;
  logic             last;
  logic             accept;

  assign last      = (sample_count == CNT_W'(AVG_SAMPLES - 1));
  // only the group-closing item needs queue space
  assign in_stall  = fifo_full && last;
  assign accept    = in_valid && !in_stall;
  assign sum_add   = sample_sum + SUM_W'(sample);
  assign push      = accept && last;
  assign push_data = sum_add;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_sum   <= '0;
      sample_count <= '0;
    end else if (accept) begin
      if (last) begin
        sample_sum   <= '0;
        sample_count <= '0;
      end else begin
        sample_sum   <= sum_add;
        sample_count <= sample_count + 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/aapm_div.sv
// Serial restoring divider, one quotient bit per cycle, unsigned operands.
module aapm_div #(
  parameter int DVD_W = 41,
  parameter int DVS_W = 12
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W);

  logic             running;
  logic [CNT_W-1:0] cnt;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [DVD_W-1:0] quo;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   trial_sub;
  logic             ge;

  assign trial     = {rem, quo[DVD_W-1]};
  assign ge        = (trial >= {1'b0, dvs});
  assign trial_sub = trial - {1'b0, dvs};
  assign quotient  = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      // pulse on the cycle after the last quotient bit
      done <= !start && running && (cnt == '0);
      if (start) begin
        running <= 1'b1;
        cnt     <= CNT_W'(DVD_W - 1);
      end else if (running) begin
        if (cnt == '0) begin
          running <= 1'b0;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (running) begin
      rem <= ge ? trial_sub[DVS_W-1:0] : trial[DVS_W-1:0];
      quo <= {quo[DVD_W-2:0], ge};
    end
  end

endmodule

>>> rtl/core/aapm_back.sv
// Back end: mean, segment pick, interpolation through the divider, saturation.
module aapm_back
  import aapm_pkg::*;
#(
  parameter int AVG_SAMPLES = 4,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                    clk,
  input  logic                    rst,
  input  cfg_t                    cfg,
  output logic                    pop,
  input  logic [SAMPLE_BITS+$clog2(AVG_SAMPLES)-1:0] pop_data,
  input  logic                    fifo_empty,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [AVG_W-1:0]        avg_raw,
  output logic signed [ANG_W-1:0] angle,
  output logic                    saturated
);

  localparam int SUM_W  = SAMPLE_BITS + $clog2(AVG_SAMPLES);
  localparam int MEAN_W = SAMPLE_BITS;
  localparam int RCP_W  = SUM_W + 1;
  localparam int PROD_W = SUM_W + RCP_W;
  localparam int MAX_W  = (MEAN_W > AVG_W) ? MEAN_W : AVG_W;
  localparam int DIFF_W = MAX_W + 1;
  localparam int NUM_W  = DIFF_W + QPI_W;
  localparam int DVD_W  = DIFF_W + QPI_W - 2;
  localparam int DVS_W  = BRK_W;
  localparam int FINE_W = DVD_W + 2;
  localparam int SAT_W  = FINE_W - FRAC_SH;
  localparam logic [RCP_W-1:0] RECIP = RCP_W'((64'd1 << SUM_W) / AVG_SAMPLES);
  localparam logic signed [SAT_W-1:0] SAT_MAX = SAT_W'(32767);
  localparam logic signed [SAT_W-1:0] SAT_MIN = SAT_W'(-32768);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MEAN_MUL,
    S_MEAN_FIX,
    S_SEG,
    S_MUL,
    S_START,
    S_DIV,
    S_FINE,
    S_SAT
  } state_t;

  state_t state;

  logic [SUM_W-1:0]         sum_q;
  logic [PROD_W-1:0]        mprod;
  logic [MEAN_W-1:0]        mean;
  seg_t                     seg;
  logic signed [DIFF_W-1:0] diff;
  logic signed [SPAN_W-1:0] span;
  logic signed [NUM_W-1:0]  prod;
  logic                     span_zero;
  logic                     neg;
  logic signed [FINE_W-1:0] frac;
  logic signed [FINE_W-1:0] fine;

  // mean correction
  logic [MEAN_W-1:0] q_est;
  logic [SUM_W-1:0]  q_back;
  logic [SUM_W-1:0]  q_rem;
  logic [MEAN_W-1:0] mean_fix;

  always_comb begin
    q_est    = mprod[SUM_W +: MEAN_W];
    q_back   = SUM_W'(SUM_W'(q_est) * SUM_W'(AVG_SAMPLES));
    q_rem    = sum_q - q_back;
    mean_fix = (q_rem >= SUM_W'(AVG_SAMPLES)) ? q_est + 1'b1 : q_est;
  end

  // segment select
  logic signed [DIFF_W-1:0] mean_s;
  logic signed [DIFF_W-1:0] brk_s [NUM_BRK];
  logic signed [DIFF_W-1:0] lo_s;
  logic signed [DIFF_W-1:0] hi_s;
  logic signed [DIFF_W-1:0] span_full;
  seg_t                     seg_sel;

  always_comb begin
    mean_s = $signed({1'b0, MAX_W'(mean)});
    for (int i = 0; i < NUM_BRK; i++) begin
      brk_s[i] = $signed({1'b0, MAX_W'(cfg.brk[i])});
    end
    if (mean_s <= brk_s[1]) begin
      seg_sel = 2'd0;
    end else if (mean_s <= brk_s[2]) begin
      seg_sel = 2'd1;
    end else if (mean_s <= brk_s[3]) begin
      seg_sel = 2'd2;
    end else begin
      seg_sel = 2'd3;
    end
    case (seg_sel)
      2'd0:    begin lo_s = brk_s[0]; hi_s = brk_s[1]; end
      2'd1:    begin lo_s = brk_s[1]; hi_s = brk_s[2]; end
      2'd2:    begin lo_s = brk_s[2]; hi_s = brk_s[3]; end
      default: begin lo_s = brk_s[3]; hi_s = brk_s[4]; end
    endcase
    span_full = hi_s - lo_s;
  end

  // divider operands are magnitudes, sign is put back afterwards
  logic signed [NUM_W-1:0]  prod_abs;
  logic signed [SPAN_W-1:0] span_abs;
  logic                     div_start;
  logic                     div_done;
  logic [DVD_W-1:0]         div_quo;
  logic signed [FINE_W-1:0] quo_s;

  assign prod_abs  = prod[NUM_W-1] ? -prod : prod;
  assign span_abs  = span[SPAN_W-1] ? -span : span;
  assign div_start = (state == S_START) && !span_zero;
  assign quo_s     = $signed({2'b00, div_quo});

  aapm_div #(
    .DVD_W (DVD_W),
    .DVS_W (DVS_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod_abs[DVD_W-1:0]),
    .divisor  (span_abs[DVS_W-1:0]),
    .done     (div_done),
    .quotient (div_quo)
  );

  // fine angle, truncate toward zero, clip
  logic signed [FINE_W-1:0] base_ext;
  logic signed [FINE_W-1:0] seg_ext;
  logic signed [FINE_W-1:0] rnd;
  logic signed [FINE_W-1:0] fine_rnd;
  logic signed [SAT_W-1:0]  ang_full;
  logic                     sat_hi;
  logic                     sat_lo;

  always_comb begin
    base_ext = $signed({{(FINE_W-ANG_W-FRAC_SH){cfg.base_angle[ANG_W-1]}},
                        cfg.base_angle, {FRAC_SH{1'b0}}});
    seg_ext  = $signed({{(FINE_W-SEG_ANG_W){1'b0}}, seg_angle(seg)});
    rnd      = fine[FINE_W-1] ? $signed(FINE_W'({FRAC_SH{1'b1}})) : '0;
    fine_rnd = fine + rnd;
    ang_full = fine_rnd[FINE_W-1:FRAC_SH];
    sat_hi   = (ang_full > SAT_MAX);
    sat_lo   = (ang_full < SAT_MIN);
  end

  // output register is empty or being taken this cycle
  logic out_free;

  assign out_free = !out_valid || !out_stall;
  assign pop      = (state == S_IDLE) && !fifo_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if ((state == S_SAT) && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!fifo_empty) begin
            sum_q <= pop_data;
            state <= S_MEAN_MUL;
          end
        end
        S_MEAN_MUL: begin
          mprod <= PROD_W'(sum_q) * PROD_W'(RECIP);
          state <= S_MEAN_FIX;
        end
        S_MEAN_FIX: begin
          mean  <= mean_fix;
          state <= S_SEG;
        end
        S_SEG: begin
          seg   <= seg_sel;
          diff  <= mean_s - lo_s;
          span  <= span_full[SPAN_W-1:0];
          state <= S_MUL;
        end
        S_MUL: begin
          prod      <= diff * QPI_FINE;
          span_zero <= (span == '0);
          state     <= S_START;
        end
        S_START: begin
          neg <= prod[NUM_W-1] ^ span[SPAN_W-1];
          if (span_zero) begin
            // flat segment lands on its upper angle
            frac  <= $signed({{(FINE_W-QPI_W){1'b0}}, QPI_FINE});
            state <= S_FINE;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            frac  <= neg ? -quo_s : quo_s;
            state <= S_FINE;
          end
        end
        S_FINE: begin
          fine  <= base_ext + seg_ext + frac;
          state <= S_SAT;
        end
        S_SAT: begin
          if (out_free) begin
            avg_raw   <= AVG_W'(MAX_W'(mean));
            saturated <= sat_hi || sat_lo;
            if (sat_hi) begin
              angle <= 16'sh7FFF;
            end else if (sat_lo) begin
              angle <= -16'sh8000;
            end else begin
              angle <= ang_full[ANG_W-1:0];
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/core/aapm_checker.sv
// Port-level checks on the angle map, bound to the top level.
`include "assert_macros.svh"

module aapm_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [11:0] avg_raw,
  input logic [15:0] angle,
  input logic        saturated
);

  // a stalled result stays put
  `AAPM_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(angle) && $stable(avg_raw) && $stable(saturated))

  // reset leaves no result pending and the input open
  `AAPM_ASSERT_AFTER_RST(a_rst_clear, clk, rst, !out_valid && !in_stall)

  // a clipped angle sits on a rail
  `AAPM_ASSERT_IMPLY(a_sat_rail, clk, rst, out_valid && saturated, angle == 16'h7FFF || angle == 16'h8000)

endmodule

bind adc_average_piecewise_angle_map_unit aapm_checker u_aapm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .avg_raw   (avg_raw),
  .angle     (angle),
  .saturated (saturated)
);
